>>> src/bcs_pkg.sv
// shared types and codes for the battery contactor sequencer
package bcs_pkg;

	typedef enum logic [3:0] {
		ST_BOOT      = 4'd0,
		ST_LV        = 4'd1,
		ST_ESC       = 4'd2,
		ST_PRECHARGE = 4'd3,
		ST_ENERGIZED = 4'd4,
		ST_DRIVE     = 4'd5,
		ST_FREE      = 4'd6,
		ST_CHARGING  = 4'd7,
		ST_BALANCE   = 4'd8,
		ST_FLT_BMS   = 4'd9,
		ST_FLT_BSPD  = 4'd10,
		ST_FLT_IMD   = 4'd11,
		ST_FLT_CHG   = 4'd12
	} state_t;

	localparam logic [3:0] CMD_TICK = 4'd13;

	typedef struct packed {
		logic [3:0] cmd;
		logic       shutdown_loop_closed;
		logic       air_minus_closed;
		logic       air_plus_closed;
	} req_t;

	typedef struct packed {
		logic [3:0] cur_state;
		logic       air_plus_drive;
		logic       precharge_drive;
		logic       shutdown_drive;
		logic       buzzer_on;
		logic       indicator_on;
		logic       stop_balance;
	} rsp_t;

	typedef struct packed {
		logic air_plus;
		logic precharge;
		logic shutdown;
		logic buzzer;
		logic indicator;
	} ctl_t;

	localparam ctl_t CTL_RESET = '{air_plus: 1'b0, precharge: 1'b0, shutdown: 1'b1,
		buzzer: 1'b0, indicator: 1'b0};
	localparam ctl_t CTL_FAULT = '{air_plus: 1'b0, precharge: 1'b0, shutdown: 1'b0,
		buzzer: 1'b1, indicator: 1'b1};

endpackage

>>> src/bcs_next.sv
// next-state, relay and flag logic for one command or tick
module bcs_next import bcs_pkg::*; (
	input  state_t     mode,
	input  ctl_t       ctl,
	input  req_t       item,
	output state_t     nxt_mode,
	output ctl_t       nxt_ctl,
	output logic       stop
);

	logic       tick;
	logic       cmd_ok;
	logic [3:0] eff;
	logic       hard;
	logic       chg_flt;

	assign tick   = (item.cmd == CMD_TICK);
	assign cmd_ok = (item.cmd <= CMD_TICK);

	// a tick turns into the command its sense lines call for
	always_comb begin
		eff = item.cmd;
		if (tick) begin
			unique case (mode) inside
				ST_ESC: begin
					if (!item.shutdown_loop_closed)
						eff = ST_LV;
					else if (item.air_minus_closed && !item.air_plus_closed)
						eff = ST_PRECHARGE;
				end
				ST_PRECHARGE: begin
					if (!item.shutdown_loop_closed || !item.air_minus_closed)
						eff = ST_LV;
					else if (item.air_plus_closed)
						eff = ST_ENERGIZED;
				end
				ST_ENERGIZED, ST_DRIVE: begin
					if (!item.shutdown_loop_closed || !item.air_minus_closed)
						eff = ST_LV;
				end
				ST_CHARGING, ST_BALANCE: begin
					if (!item.air_minus_closed)
						eff = ST_FREE;
				end
				default: eff = item.cmd;
			endcase
		end
	end

	assign hard    = (eff == ST_FLT_BMS) || (eff == ST_FLT_BSPD) || (eff == ST_FLT_IMD);
	// bspd is ignored once off the drive path
	assign chg_flt = (eff == ST_FLT_BMS) || (eff == ST_FLT_IMD);

	// next state
	always_comb begin
		nxt_mode = mode;
		if (cmd_ok) begin
			unique case (mode) inside
				ST_BOOT, ST_LV, ST_ESC, ST_PRECHARGE, ST_ENERGIZED, ST_DRIVE: begin
					if (hard) begin
						case (eff)
							ST_FLT_BMS:  nxt_mode = ST_FLT_BMS;
							ST_FLT_BSPD: nxt_mode = ST_FLT_BSPD;
							default:     nxt_mode = ST_FLT_IMD;
						endcase
					end else begin
						case (mode)
							ST_BOOT: begin
								if (tick || eff == ST_LV)
									nxt_mode = ST_LV;
							end
							ST_LV: begin
								if (eff == ST_ESC)
									nxt_mode = ST_ESC;
								else if (eff == ST_FREE)
									nxt_mode = ST_FREE;
								else if (tick && item.shutdown_loop_closed)
									nxt_mode = ST_ESC;
							end
							ST_ESC: begin
								if (eff == ST_LV)
									nxt_mode = ST_LV;
								else if (eff == ST_PRECHARGE)
									nxt_mode = ST_PRECHARGE;
							end
							ST_PRECHARGE: begin
								if (eff == ST_LV)
									nxt_mode = ST_LV;
								else if (eff == ST_ESC)
									nxt_mode = ST_ESC;
								else if (eff == ST_ENERGIZED)
									nxt_mode = ST_ENERGIZED;
							end
							default: begin
								if (eff == ST_LV)
									nxt_mode = ST_LV;
								else if (eff == ST_ESC)
									nxt_mode = ST_ESC;
								else if (mode == ST_ENERGIZED && eff == ST_DRIVE)
									nxt_mode = ST_DRIVE;
								else if (mode == ST_DRIVE && eff == ST_ENERGIZED)
									nxt_mode = ST_ENERGIZED;
							end
						endcase
					end
				end
				ST_FREE: begin
					if (chg_flt)
						nxt_mode = ST_FLT_CHG;
					else if (eff == ST_FREE || eff == ST_LV)
						nxt_mode = ST_FREE;
					else if (eff == ST_CHARGING)
						nxt_mode = ST_CHARGING;
					else if (eff == ST_BALANCE)
						nxt_mode = ST_BALANCE;
				end
				ST_CHARGING, ST_BALANCE: begin
					if (chg_flt)
						nxt_mode = ST_FLT_CHG;
					else if (eff == ST_LV || eff == ST_FREE)
						nxt_mode = ST_FREE;
				end
				default: nxt_mode = mode;
			endcase
		end
	end

	// relay drives and the balance stop flag
	always_comb begin
		nxt_ctl = ctl;
		stop    = 1'b0;
		if (cmd_ok) begin
			unique case (mode) inside
				ST_BOOT, ST_LV: begin
					if (hard)
						nxt_ctl = CTL_FAULT;
				end
				ST_ESC: begin
					if (hard) begin
						nxt_ctl = CTL_FAULT;
					end else if (eff == ST_PRECHARGE) begin
						nxt_ctl.air_plus  = 1'b0;
						nxt_ctl.precharge = 1'b1;
					end
				end
				ST_PRECHARGE: begin
					if (hard) begin
						nxt_ctl = CTL_FAULT;
					end else if (eff == ST_LV || eff == ST_ESC) begin
						nxt_ctl.air_plus  = 1'b0;
						nxt_ctl.precharge = 1'b0;
					end else if (eff == ST_ENERGIZED) begin
						nxt_ctl.air_plus  = 1'b1;
						nxt_ctl.precharge = 1'b0;
					end
				end
				ST_ENERGIZED, ST_DRIVE: begin
					if (hard) begin
						nxt_ctl = CTL_FAULT;
					end else if (eff == ST_LV || eff == ST_ESC) begin
						nxt_ctl.air_plus  = 1'b0;
						nxt_ctl.precharge = 1'b0;
					end
				end
				ST_FREE: begin
					if (chg_flt)
						nxt_ctl = CTL_FAULT;
					else if (eff == ST_FREE || eff == ST_LV)
						nxt_ctl.air_plus = 1'b0;
					else if (eff == ST_CHARGING)
						nxt_ctl.air_plus = 1'b1;
				end
				ST_CHARGING, ST_BALANCE: begin
					if (chg_flt) begin
						nxt_ctl = CTL_FAULT;
						stop    = (mode == ST_BALANCE);
					end else if (eff == ST_LV || eff == ST_FREE) begin
						nxt_ctl.air_plus  = 1'b0;
						nxt_ctl.precharge = 1'b0;
						stop              = (mode == ST_BALANCE);
					end
				end
				default: begin
					// fault states hold, any command re-asserts the fault outputs
					if (!tick)
						nxt_ctl = CTL_FAULT;
				end
			endcase
		end
	end

endmodule

>>> src/battery_contactor_sequencer_top.sv
// battery contactor sequencer: input stage, state registers and result register
//
// req carries one command or process tick per beat; rsp returns one result beat
// per request beat, in order: the state after the item, the relay, buzzer and
// indicator drives, and the stop-balance pulse.
// both channels are valid/ready; a beat moves when valid and ready are high.
// order: a request beat is captured in the input stage; when it leaves the
// input stage its result is written to the output register, which drives
// rsp_valid and rsp.
// throughput: one beat per cycle while rsp_ready stays high, set by the single
// pass of next-state logic between the input stage and the output register.
// the sequencer state is written when an item leaves the input stage, so the
// item right behind it sees the updated state.
// when the receiver stalls, the output register holds its beat, the input
// stage fills and req_ready falls; nothing is dropped.
// reset (arst_n low) returns to boot with all relays open, shutdown relay
// closed, buzzer and indicator off, and both stages empty.
module battery_contactor_sequencer_top import bcs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	req_t   req_s1;
	logic   vld_s1;
	rsp_t   rsp_s2;
	logic   vld_s2;
	state_t mode_q;
	ctl_t   ctl_q;

	state_t nxt_mode;
	ctl_t   nxt_ctl;
	logic   stop;
	logic   adv;

	assign adv       = vld_s1 && (!vld_s2 || rsp_ready);
	assign req_ready = !vld_s1 || adv;

	bcs_next u_next (
		.mode     (mode_q),
		.ctl      (ctl_q),
		.item     (req_s1),
		.nxt_mode (nxt_mode),
		.nxt_ctl  (nxt_ctl),
		.stop     (stop)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			mode_q <= ST_BOOT;
			ctl_q  <= CTL_RESET;
		end else begin
			if (req_ready)
				vld_s1 <= req_valid;
			if (adv) begin
				vld_s2 <= 1'b1;
				mode_q <= nxt_mode;
				ctl_q  <= nxt_ctl;
			end else if (rsp_ready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid)
			req_s1 <= req;
		if (adv) begin
			rsp_s2.cur_state       <= nxt_mode;
			rsp_s2.air_plus_drive  <= nxt_ctl.air_plus;
			rsp_s2.precharge_drive <= nxt_ctl.precharge;
			rsp_s2.shutdown_drive  <= nxt_ctl.shutdown;
			rsp_s2.buzzer_on       <= nxt_ctl.buzzer;
			rsp_s2.indicator_on    <= nxt_ctl.indicator;
			rsp_s2.stop_balance    <= stop;
		end
	end

	assign rsp_valid = vld_s2;
	assign rsp       = rsp_s2;

endmodule

>>> verif/testbench.sv
// self-checking testbench for the battery contactor sequencer
`timescale 1ns / 1ps

module testbench;
	import bcs_pkg::*;

	localparam logic [3:0] CMD_SPARE_LO = 4'd14;
	localparam logic [3:0] CMD_SPARE_HI = 4'd15;

	typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	// shadow of the sequencer
	state_t pk_state;
	ctl_t   pk_ctl;

	rsp_t status_due[$];
	int   fail_count = 0;
	int   burst_left;
	int   gap_len;

	battery_contactor_sequencer_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("** battery_contactor_sequencer_top: FAILED **");
		$finish;
	end

	function automatic bit is_trip_cmd(logic [3:0] c);
		return c == ST_FLT_BMS || c == ST_FLT_BSPD || c == ST_FLT_IMD;
	endfunction

	function automatic void trip(state_t s);
		pk_state = s;
		pk_ctl = CTL_FAULT;
	endfunction

	function automatic void open_relays();
		pk_ctl.air_plus = 1'b0;
		pk_ctl.precharge = 1'b0;
	endfunction

	// next state and drives for one beat, returns the status it should produce
	function automatic rsp_t step_sequencer(req_t r);
		logic [3:0] c;
		logic tick;
		logic loop_ok;
		logic am;
		logic ap;
		logic stop;
		rsp_t o;
		c = r.cmd;
		tick = (c == CMD_TICK);
		loop_ok = r.shutdown_loop_closed;
		am = r.air_minus_closed;
		ap = r.air_plus_closed;
		stop = 1'b0;
		if (c <= CMD_TICK) begin
			case (pk_state)
			ST_BOOT: begin
				if (is_trip_cmd(c)) trip(state_t'(c));
				else if (tick || c == ST_LV) pk_state = ST_LV;
			end
			ST_LV: begin
				if (is_trip_cmd(c)) trip(state_t'(c));
				else if (c == ST_ESC || c == ST_FREE) pk_state = state_t'(c);
				else if (tick && loop_ok) pk_state = ST_ESC;
			end
			ST_ESC: begin
				if (tick) begin
					if (!loop_ok) c = ST_LV;
					else if (am && !ap) c = ST_PRECHARGE;
				end
				if (is_trip_cmd(c)) trip(state_t'(c));
				else if (c == ST_LV) pk_state = ST_LV;
				else if (c == ST_PRECHARGE) begin
					pk_ctl.air_plus = 1'b0;
					pk_ctl.precharge = 1'b1;
					pk_state = ST_PRECHARGE;
				end
			end
			ST_PRECHARGE: begin
				if (tick) begin
					if (!loop_ok || !am) c = ST_LV;
					else if (ap) c = ST_ENERGIZED;
				end
				if (is_trip_cmd(c)) trip(state_t'(c));
				else if (c == ST_LV || c == ST_ESC) begin
					open_relays();
					pk_state = state_t'(c);
				end else if (c == ST_ENERGIZED) begin
					pk_ctl.air_plus = 1'b1;
					pk_ctl.precharge = 1'b0;
					pk_state = ST_ENERGIZED;
				end
			end
			ST_ENERGIZED, ST_DRIVE: begin
				if (tick && (!loop_ok || !am)) c = ST_LV;
				if (is_trip_cmd(c)) trip(state_t'(c));
				else if (c == ST_LV || c == ST_ESC) begin
					open_relays();
					pk_state = state_t'(c);
				end else if (pk_state == ST_ENERGIZED && c == ST_DRIVE) pk_state = ST_DRIVE;
				else if (pk_state == ST_DRIVE && c == ST_ENERGIZED) pk_state = ST_ENERGIZED;
			end
			ST_FREE: begin
				// bspd is not a fault on the charger side
				if (c == ST_FLT_BMS || c == ST_FLT_IMD) trip(ST_FLT_CHG);
				else if (c == ST_FREE || c == ST_LV) begin
					pk_ctl.air_plus = 1'b0;
					pk_state = ST_FREE;
				end else if (c == ST_CHARGING) begin
					pk_ctl.air_plus = 1'b1;
					pk_state = ST_CHARGING;
				end else if (c == ST_BALANCE) pk_state = ST_BALANCE;
			end
			ST_CHARGING, ST_BALANCE: begin
				if (tick && !am) c = ST_FREE;
				if (c == ST_FLT_BMS || c == ST_FLT_IMD) begin
					stop = (pk_state == ST_BALANCE);
					trip(ST_FLT_CHG);
				end else if (c == ST_LV || c == ST_FREE) begin
					open_relays();
					stop = (pk_state == ST_BALANCE);
					pk_state = ST_FREE;
				end
			end
			default: begin
				// fault states hold; commands re-assert the fault drives
				if (!tick) trip(pk_state);
			end
			endcase
		end
		o.cur_state = pk_state;
		o.air_plus_drive = pk_ctl.air_plus;
		o.precharge_drive = pk_ctl.precharge;
		o.shutdown_drive = pk_ctl.shutdown;
		o.buzzer_on = pk_ctl.buzzer;
		o.indicator_on = pk_ctl.indicator;
		o.stop_balance = stop;
		return o;
	endfunction

	function automatic req_t beat_of(logic [3:0] c, bit loop_ok, bit am, bit ap);
		req_t r;
		r.cmd = c;
		r.shutdown_loop_closed = loop_ok;
		r.air_minus_closed = am;
		r.air_plus_closed = ap;
		return r;
	endfunction

	// random beat that never trips a fault; the drive side also never enters free
	function automatic req_t pick_beat(bit free_side);
		req_t r;
		r.shutdown_loop_closed = ($urandom_range(0, 9) < 8);
		r.air_minus_closed = ($urandom_range(0, 9) < 8);
		r.air_plus_closed = 1'($urandom_range(0, 1));
		r.cmd = ($urandom_range(0, 1) != 0) ? CMD_TICK : 4'($urandom_range(0, 15));
		if (r.cmd == ST_FLT_BMS || r.cmd == ST_FLT_IMD) r.cmd = CMD_TICK;
		else if (!free_side && (r.cmd == ST_FLT_BSPD || r.cmd == ST_FREE)) r.cmd = CMD_TICK;
		return r;
	endfunction

	task automatic send_item(req_t item);
		@(negedge clk);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		status_due.push_back(step_sequencer(item));
		burst_left--;
		if (burst_left == 0) begin
			if ($urandom_range(0, 5) == 0) begin
				burst_left = $urandom_range(40, 150);
				gap_len = 0;
			end else begin
				burst_left = $urandom_range(1, 12);
				gap_len = $urandom_range(0, 8);
			end
			if (gap_len != 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap_len - 1) @(negedge clk);
			end
		end
	endtask

	// stop sending until every status beat is back
	task automatic hold_off();
		@(negedge clk);
		req_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	task automatic test_boot_path();
		send_item(beat_of(CMD_SPARE_HI, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(CMD_SPARE_LO, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_BOOT, 1'b1, 1'b0, 1'b1));
		send_item(beat_of(ST_FLT_CHG, 1'b1, 1'b1, 1'b0));
		send_item(beat_of(ST_ENERGIZED, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(CMD_TICK, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_FLT_CHG, 1'b0, 1'b1, 1'b1));
		send_item(beat_of(CMD_TICK, 1'b0, 1'b1, 1'b1));
		send_item(beat_of(CMD_TICK, 1'b1, 1'b0, 1'b0));
		hold_off();
	endtask

	task automatic test_drive_walk();
		send_item(beat_of(CMD_TICK, 1'b1, 1'b0, 1'b0));
		send_item(beat_of(CMD_TICK, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_PRECHARGE, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(CMD_TICK, 1'b1, 1'b0, 1'b1));
		send_item(beat_of(ST_ESC, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(CMD_TICK, 1'b1, 1'b1, 1'b0));
		send_item(beat_of(CMD_TICK, 1'b1, 1'b1, 1'b0));
		send_item(beat_of(CMD_TICK, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_DRIVE, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_ENERGIZED, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_DRIVE, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(CMD_TICK, 1'b0, 1'b1, 1'b1));
		send_item(beat_of(ST_ESC, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_PRECHARGE, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_ENERGIZED, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_ESC, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_LV, 1'b1, 1'b1, 1'b1));
		hold_off();
	endtask

	task automatic test_drive_random(int count);
		repeat (count / 2) send_item(pick_beat(1'b0));
		hold_off();
		repeat (count - count / 2) send_item(pick_beat(1'b0));
		hold_off();
	endtask

	// the charger side has no way back to the drive side
	task automatic test_free_side(int count);
		send_item(beat_of(ST_LV, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_FREE, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_FLT_BSPD, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_LV, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_CHARGING, 1'b1, 1'b1, 1'b0));
		send_item(beat_of(ST_FLT_BSPD, 1'b0, 1'b1, 1'b0));
		send_item(beat_of(CMD_TICK, 1'b1, 1'b0, 1'b1));
		send_item(beat_of(ST_BALANCE, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_LV, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_BALANCE, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(CMD_TICK, 1'b0, 1'b0, 1'b0));
		send_item(beat_of(ST_CHARGING, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_FREE, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_BALANCE, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_FLT_CHG, 1'b1, 1'b1, 1'b1));
		send_item(beat_of(ST_FREE, 1'b1, 1'b1, 1'b1));
		repeat (count) send_item(pick_beat(1'b1));
		hold_off();
	endtask

	// one fault per run, since only reset leaves a fault state
	task automatic test_fault_latch(bit hard);
		req_t r;
		if (hard) begin
			r = pick_beat(1'b0);
			r.cmd = 4'($urandom_range(ST_FLT_BMS, ST_FLT_IMD));
			send_item(r);
		end else begin
			send_item(beat_of(ST_LV, 1'b1, 1'b1, 1'b1));
			if ($urandom_range(0, 2) == 0)
				send_item(beat_of(ST_CHARGING, 1'b1, 1'b1, 1'b0));
			else if ($urandom_range(0, 1) == 0)
				send_item(beat_of(ST_BALANCE, 1'b1, 1'b1, 1'b0));
			r = pick_beat(1'b1);
			r.cmd = ($urandom_range(0, 1) != 0) ? ST_FLT_BMS : ST_FLT_IMD;
			send_item(r);
		end
		repeat (40) begin
			r.cmd = 4'($urandom_range(0, 15));
			r.shutdown_loop_closed = 1'($urandom_range(0, 1));
			r.air_minus_closed = 1'($urandom_range(0, 1));
			r.air_plus_closed = 1'($urandom_range(0, 1));
			send_item(r);
		end
		hold_off();
	endtask

	// receiver stall patterns
	initial begin : rx_pattern
		rx_style_t style;
		int span;
		int period;
		rsp_ready = 1'b0;
		forever begin
			style = rx_style_t'($urandom_range(RX_OPEN, RX_PERIODIC));
			span = $urandom_range(20, 200);
			period = $urandom_range(2, 7);
			for (int k = 0; k < span; k++) begin
				@(negedge clk);
				case (style)
				RX_OPEN: rsp_ready <= 1'b1;
				RX_COIN: rsp_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= ((k % period) != 0);
				endcase
			end
		end
	end

	task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (status_due.size() == 0) begin
				$error("status beat with nothing outstanding: state %0d", rsp.cur_state);
				fail_count++;
			end else begin
				want = status_due.pop_front();
				check_field("cur_state", want.cur_state, rsp.cur_state);
				check_field("air_plus_drive", 4'(want.air_plus_drive),
					4'(rsp.air_plus_drive));
				check_field("precharge_drive", 4'(want.precharge_drive),
					4'(rsp.precharge_drive));
				check_field("shutdown_drive", 4'(want.shutdown_drive),
					4'(rsp.shutdown_drive));
				check_field("buzzer_on", 4'(want.buzzer_on), 4'(rsp.buzzer_on));
				check_field("indicator_on", 4'(want.indicator_on), 4'(rsp.indicator_on));
				check_field("stop_balance", 4'(want.stop_balance), 4'(rsp.stop_balance));
			end
		end
	end

	initial begin
		bit hard_end;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		pk_state = ST_BOOT;
		pk_ctl = CTL_RESET;
		burst_left = 1;
		gap_len = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// half the runs end in a drive-side fault, the rest go through the charger side
		hard_end = 1'($urandom_range(0, 1));
		test_boot_path();
		test_drive_walk();
		test_drive_random(hard_end ? 1600 : 900);
		if (!hard_end) test_free_side(700);
		test_fault_latch(hard_end);
		hold_off();
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("** battery_contactor_sequencer_top: PASSED **");
		else
			$display("** battery_contactor_sequencer_top: FAILED **");
		$finish;
	end

endmodule
